>>> hw/rtl/tmh_pkg.sv
// Shared types, codes and helpers for the timer min-heap scheduler.
// No dependencies; imported by every module of the block but tmh_ram.
`default_nettype none
package tmh_pkg;

    localparam int TIMERS    = 64;
    localparam int ID_W      = 6;
    localparam int TIME_W    = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int DEF_SLOTS = 64;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ACTIVE     = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [ID_W-1:0]   owner;
        logic [TIME_W-1:0] interval;
        logic              repeats;
    } heap_entry_t;

    localparam int ENTRY_W = $bits(heap_entry_t);

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic                fired;
        logic [ID_W-1:0]     fired_id;
        logic [COUNT_W-1:0]  active_count;
    } result_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tmh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/tmh_seq.sv
// Command sequencer: decodes a command and walks the heap through the
// heap and position RAMs. Depends on tmh_pkg.
`default_nettype none
module tmh_seq #(
    parameter int SLOTS = tmh_pkg::DEF_SLOTS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [tmh_pkg::CMD_W-1:0]   in_command,
    input  wire logic [tmh_pkg::ID_W-1:0]    in_timer_id,
    input  wire logic [tmh_pkg::TIME_W-1:0]  in_interval_ms,
    input  wire logic                        in_periodic,
    input  wire logic [tmh_pkg::TIME_W-1:0]  in_now_ms,
    output tmh_pkg::result_t                 res,
    input  wire logic                        out_free,
    output logic                             heap_we,
    output logic [$clog2(SLOTS)-1:0]         heap_waddr,
    output tmh_pkg::heap_entry_t             heap_wdata,
    output logic [$clog2(SLOTS)-1:0]         heap_raddr,
    input  wire tmh_pkg::heap_entry_t        heap_rdata,
    output logic                             pos_we,
    output logic [tmh_pkg::ID_W-1:0]         pos_waddr,
    output logic [$clog2(SLOTS)-1:0]         pos_wdata,
    output logic [tmh_pkg::ID_W-1:0]         pos_raddr,
    input  wire logic [$clog2(SLOTS)-1:0]    pos_rdata
);
    import tmh_pkg::*;

    localparam int PW = $clog2(SLOTS);
    localparam int NW = PW + 2;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INS    = 4'd1;
    localparam logic [3:0] S_RPOS   = 4'd2;
    localparam logic [3:0] S_RLAST  = 4'd3;
    localparam logic [3:0] S_TROOT  = 4'd4;
    localparam logic [3:0] S_UP_RD  = 4'd5;
    localparam logic [3:0] S_UP_CMP = 4'd6;
    localparam logic [3:0] S_DN_RD  = 4'd7;
    localparam logic [3:0] S_DN_L   = 4'd8;
    localparam logic [3:0] S_DN_R   = 4'd9;
    localparam logic [3:0] S_DN_CMP = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0]          state_reg, state_next;
    logic [NW-1:0]       size_reg, size_next;
    logic [TIMERS-1:0]   armed_reg, armed_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    heap_entry_t         e_reg, e_next;
    heap_entry_t         ins_reg, ins_next;
    heap_entry_t         left_reg, left_next;
    heap_entry_t         pick_reg, pick_next;
    logic                reins_reg, reins_next;
    logic                maydown_reg, maydown_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [PW-1:0]       pickpos_reg, pickpos_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                fired_reg, fired_next;
    logic [ID_W-1:0]     fid_reg, fid_next;

    logic [PW-1:0] parent;
    logic [NW-1:0] kid;
    logic [NW-1:0] last;

    assign parent   = (pos_reg - PW'(1)) >> 1;
    assign kid      = (NW'(pos_reg) << 1) + NW'(1);
    assign last     = size_reg - NW'(1);
    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        res.valid        = (state_reg == S_DONE);
        res.status       = status_reg;
        res.fired        = fired_reg;
        res.fired_id     = fid_reg;
        res.active_count = COUNT_W'(size_reg);
    end

    always_comb begin
        state_next   = state_reg;
        size_next    = size_reg;
        armed_next   = armed_reg;
        now_next     = now_reg;
        e_next       = e_reg;
        ins_next     = ins_reg;
        left_next    = left_reg;
        pick_next    = pick_reg;
        reins_next   = reins_reg;
        maydown_next = maydown_reg;
        pos_next     = pos_reg;
        pickpos_next = pickpos_reg;
        status_next  = status_reg;
        fired_next   = fired_reg;
        fid_next     = fid_reg;
        heap_we      = 1'b0;
        heap_waddr   = pos_reg;
        heap_wdata   = e_reg;
        heap_raddr   = '0;
        pos_we       = 1'b0;
        pos_waddr    = e_reg.owner;
        pos_wdata    = pos_reg;
        pos_raddr    = in_timer_id;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    now_next    = in_now_ms;
                    status_next = ST_OK;
                    fired_next  = 1'b0;
                    fid_next    = '0;
                    reins_next  = 1'b0;
                    state_next  = S_DONE;
                    case (in_command)
                        CMD_ADD: begin
                            if (armed_reg[in_timer_id]) begin
                                status_next = ST_ACTIVE;
                            end else if (size_reg >= NW'(SLOTS)) begin
                                status_next = ST_FULL;
                            end else begin
                                ins_next.expiry   = sat_add(in_now_ms, in_interval_ms);
                                ins_next.owner    = in_timer_id;
                                ins_next.interval = in_interval_ms;
                                ins_next.repeats  = in_periodic;
                                state_next        = S_INS;
                            end
                        end
                        CMD_REMOVE: begin
                            if (!armed_reg[in_timer_id]) begin
                                status_next = ST_NOT_ACTIVE;
                            end else begin
                                armed_next[in_timer_id] = 1'b0;
                                state_next              = S_RPOS;
                            end
                        end
                        CMD_TICK: begin
                            if (size_reg != '0) begin
                                state_next = S_TROOT;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_INS: begin
                e_next                  = ins_reg;
                armed_next[ins_reg.owner] = 1'b1;
                pos_next                = PW'(size_reg);
                size_next               = size_reg + NW'(1);
                reins_next              = 1'b0;
                maydown_next            = 1'b0;
                state_next              = S_UP_RD;
            end
            S_RPOS: begin
                size_next = last;
                if (NW'(pos_rdata) == last) begin
                    state_next = S_DONE;
                end else begin
                    heap_raddr = PW'(last);
                    pos_next   = pos_rdata;
                    state_next = S_RLAST;
                end
            end
            S_RLAST: begin
                e_next = heap_rdata;
                if (pos_reg == '0) begin
                    state_next = S_DN_RD;
                end else begin
                    maydown_next = 1'b1;
                    state_next   = S_UP_RD;
                end
            end
            S_TROOT: begin
                if (heap_rdata.expiry <= now_reg) begin
                    fired_next                   = 1'b1;
                    fid_next                     = heap_rdata.owner;
                    armed_next[heap_rdata.owner] = 1'b0;
                    ins_next                     = heap_rdata;
                    ins_next.expiry = sat_add(now_reg, heap_rdata.interval);
                    reins_next                   = heap_rdata.repeats;
                    size_next                    = last;
                    if (last == '0) begin
                        state_next = heap_rdata.repeats ? S_INS : S_DONE;
                    end else begin
                        heap_raddr = PW'(last);
                        pos_next   = '0;
                        state_next = S_RLAST;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_UP_RD: begin
                if (pos_reg == '0) begin
                    state_next = maydown_reg ? S_DN_RD : S_FIN;
                end else begin
                    heap_raddr = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (e_reg.expiry < heap_rdata.expiry) begin
                    heap_we      = 1'b1;
                    heap_wdata   = heap_rdata;
                    pos_we       = 1'b1;
                    pos_waddr    = heap_rdata.owner;
                    pos_next     = parent;
                    maydown_next = 1'b0;
                    state_next   = S_UP_RD;
                end else begin
                    state_next = maydown_reg ? S_DN_RD : S_FIN;
                end
            end
            S_DN_RD: begin
                if (kid >= size_reg) begin
                    state_next = S_FIN;
                end else begin
                    heap_raddr = PW'(kid);
                    state_next = S_DN_L;
                end
            end
            S_DN_L: begin
                left_next    = heap_rdata;
                pick_next    = heap_rdata;
                pickpos_next = PW'(kid);
                if (kid + NW'(1) < size_reg) begin
                    heap_raddr = PW'(kid + NW'(1));
                    state_next = S_DN_R;
                end else begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_R: begin
                if (!(left_reg.expiry < heap_rdata.expiry)) begin
                    pick_next    = heap_rdata;
                    pickpos_next = PW'(kid + NW'(1));
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (e_reg.expiry < pick_reg.expiry) begin
                    state_next = S_FIN;
                end else begin
                    heap_we    = 1'b1;
                    heap_wdata = pick_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = pick_reg.owner;
                    pos_next   = pickpos_reg;
                    state_next = S_DN_RD;
                end
            end
            S_FIN: begin
                heap_we    = 1'b1;
                pos_we     = 1'b1;
                state_next = reins_reg ? S_INS : S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            size_reg    <= '0;
            armed_reg   <= '0;
            reins_reg   <= 1'b0;
            maydown_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            size_reg    <= size_next;
            armed_reg   <= armed_next;
            reins_reg   <= reins_next;
            maydown_reg <= maydown_next;
        end
        now_reg     <= now_next;
        e_reg       <= e_next;
        ins_reg     <= ins_next;
        left_reg    <= left_next;
        pick_reg    <= pick_next;
        pos_reg     <= pos_next;
        pickpos_reg <= pickpos_next;
        status_reg  <= status_next;
        fired_reg   <= fired_next;
        fid_reg     <= fid_next;
    end
endmodule
`default_nettype wire

>>> hw/rtl/timer_min_heap_scheduler.sv
// Top level of the timer min-heap scheduler: sequencer, heap RAM,
// position RAM and result register. Depends on tmh_pkg, tmh_ram, tmh_seq.
//
//   channel  | ports      | beat carries
//   ---------+------------+-----------------------------------------------
//   input    | s_valid/   | command, timer_id, interval_ms, periodic,
//            | s_ready    | now_ms
//   result   | m_valid/   | status, fired, fired_id, active_count
//            | m_ready    |
//
// One command at a time. Rejected commands, unused codes and ticks on an
// empty heap go straight to the result; a tick with nothing due reads the
// root first, and a remove of the last entry reads its position only. An add
// climbs level by level and writes the entry where it stops. Other removes
// and firing ticks move the last entry into the gap, then climb it, or sink
// it level by level (left read, right read, compare/move), with a final write,
// and a periodic timer is put back and climbs again; the heap RAM has a
// single read port, so each level reads one entry at a time.
// Reset clears the heap size and the armed bits; RAM contents are not reset.
// A waiting result sits in the output register while the next beat is taken;
// the sequencer holds only if a second result is ready before the first left.
`default_nettype none
module timer_min_heap_scheduler #(
    parameter int SLOTS = tmh_pkg::DEF_SLOTS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [tmh_pkg::CMD_W-1:0]     s_command,
    input  wire logic [tmh_pkg::ID_W-1:0]      s_timer_id,
    input  wire logic [tmh_pkg::TIME_W-1:0]    s_interval_ms,
    input  wire logic                          s_periodic,
    input  wire logic [tmh_pkg::TIME_W-1:0]    s_now_ms,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [tmh_pkg::STATUS_W-1:0]       m_status,
    output logic                               m_fired,
    output logic [tmh_pkg::ID_W-1:0]           m_fired_id,
    output logic [tmh_pkg::COUNT_W-1:0]        m_active_count
);
    import tmh_pkg::*;

    localparam int PW = $clog2(SLOTS);

    result_t     res;
    logic        out_free;
    logic        heap_we;
    logic [PW-1:0] heap_waddr, heap_raddr;
    heap_entry_t heap_wdata, heap_rdata;
    logic        pos_we;
    logic [ID_W-1:0] pos_waddr, pos_raddr;
    logic [PW-1:0] pos_wdata, pos_rdata;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                fired_reg;
    logic [ID_W-1:0]     fid_reg;
    logic [COUNT_W-1:0]  count_reg;

    // Output register frees when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;

    tmh_seq #(.SLOTS(SLOTS)) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .in_command     (s_command),
        .in_timer_id    (s_timer_id),
        .in_interval_ms (s_interval_ms),
        .in_periodic    (s_periodic),
        .in_now_ms      (s_now_ms),
        .res            (res),
        .out_free       (out_free),
        .heap_we        (heap_we),
        .heap_waddr     (heap_waddr),
        .heap_wdata     (heap_wdata),
        .heap_raddr     (heap_raddr),
        .heap_rdata     (heap_rdata),
        .pos_we         (pos_we),
        .pos_waddr      (pos_waddr),
        .pos_wdata      (pos_wdata),
        .pos_raddr      (pos_raddr),
        .pos_rdata      (pos_rdata)
    );

    // Heap entries: expiry, owner, interval and periodic flag travel together.
    tmh_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_heap_ram (
        .aclk  (aclk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    // Heap index of each timer.
    tmh_ram #(.WIDTH(PW), .DEPTH(TIMERS)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res.valid && out_free) begin
            status_reg <= res.status;
            fired_reg  <= res.fired;
            fid_reg    <= res.fired_id;
            count_reg  <= res.active_count;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_fired        = fired_reg;
    assign m_fired_id     = fid_reg;
    assign m_active_count = count_reg;
endmodule
`default_nettype wire

>>> hw/rtl/tmh_check.sv
// Port-level checker for the timer min-heap scheduler, bound to the top.
// Depends on tmh_pkg.
`default_nettype none
module tmh_check (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [tmh_pkg::STATUS_W-1:0]  m_status,
    input wire logic                          m_fired,
    input wire logic [tmh_pkg::ID_W-1:0]      m_fired_id,
    input wire logic [tmh_pkg::COUNT_W-1:0]   m_active_count
);
    import tmh_pkg::*;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped before accept");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_status) && $stable(m_fired_id)
                               && $stable(m_active_count))
        else $error("stalled result changed");

    a_quiet_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_fired |-> m_fired_id == '0)
        else $error("fired_id set without a firing");

    a_fire_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fired |-> m_status == ST_OK)
        else $error("firing with error status");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_active_count <= COUNT_W'(TIMERS))
        else $error("active count beyond timer count");
endmodule

bind timer_min_heap_scheduler tmh_check u_tmh_check (.*);
`default_nettype wire
